[hw/rtl/vsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_pkg
// Types, layout tables and helpers shared by the vertex stride decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

	localparam int unsigned MAX_STRIDE     = 544;
	localparam int unsigned MAX_POS_OFFSET = 56;
	localparam int unsigned MAX_PAD_OFFSET = 68;

	// bytes of each component, indexed by its format code
	localparam logic [3:0] TC_BYTES  [4] = '{4'd0, 4'd2, 4'd4, 4'd8};
	localparam logic [2:0] COL_BYTES [8] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd4};
	localparam logic [3:0] NRM_BYTES [4] = '{4'd0, 4'd3, 4'd6, 4'd12};
	localparam logic [3:0] POS_BYTES [4] = '{4'd3, 4'd3, 4'd6, 4'd12};
	// element alignment, also the element size
	localparam logic [2:0] ELEM_ALIGN [4] = '{3'd0, 3'd1, 3'd2, 3'd4};
	localparam logic [2:0] POS_ALIGN  [4] = '{3'd1, 3'd1, 3'd2, 3'd4};

	typedef struct packed {
		logic [1:0] tex_coord_format;
		logic [2:0] color_format;
		logic [1:0] normal_format;
		logic [1:0] position_format;
		logic [1:0] weight_format;
		logic [3:0] weight_count;
		logic [3:0] morph_count;
	} fmt_t;

	typedef struct packed {
		logic [9:0] vertex_stride;
		logic [5:0] position_offset;
		logic [6:0] padding_offset;
	} layout_t;

	// clamp a count to 1..8
	function automatic logic [3:0] vsd_sat_count(input logic [3:0] cnt);
		logic [3:0] res;
		res = cnt;
		if (cnt == 4'd0) begin
			res = 4'd1;
		end else if (cnt > 4'd8) begin
			res = 4'd8;
		end
		return res;
	endfunction

	// round size up to a power-of-two alignment
	function automatic logic [6:0] vsd_align(input logic [6:0] size, input logic [2:0] align);
		logic [7:0] m;
		logic [7:0] sum;
		m = (align == 3'd0) ? 8'd0 : ({5'd0, align} - 8'd1);
		sum = ({1'b0, size} + m) & ~m;
		return sum[6:0];
	endfunction

endpackage

[hw/rtl/vsd_layout.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_layout
// Lays out the vertex components in order and derives stride and offsets.
// ----------------------------------------------------------------------------
module vsd_layout
	import vsd_pkg::*;
(
	input  fmt_t    fmt,
	output layout_t layout
);

	always_comb begin
		logic [3:0] wc;
		logic [3:0] mc;
		logic [2:0] a;
		logic [2:0] big;
		logic [6:0] size;
		logic [6:0] aligned;
		logic [6:0] pad;
		logic [6:0] posoff;
		logic       seen;

		wc = vsd_sat_count(fmt.weight_count);
		mc = vsd_sat_count(fmt.morph_count);
		size = 7'd0;
		big = 3'd0;
		pad = 7'd0;
		seen = 1'b0;

		// weights start at offset zero, no alignment step
		if (fmt.weight_format != 2'd0) begin
			a = ELEM_ALIGN[fmt.weight_format];
			size = {3'd0, wc} * {4'd0, a};
			if (a > big) big = a;
		end

		if (fmt.tex_coord_format != 2'd0) begin
			a = ELEM_ALIGN[fmt.tex_coord_format];
			aligned = vsd_align(size, a);
			if (!seen && aligned != size) begin
				seen = 1'b1;
				pad = size;
			end
			size = aligned + {3'd0, TC_BYTES[fmt.tex_coord_format]};
			if (a > big) big = a;
		end

		if (COL_BYTES[fmt.color_format] != 3'd0) begin
			a = COL_BYTES[fmt.color_format];
			aligned = vsd_align(size, a);
			if (!seen && aligned != size) begin
				seen = 1'b1;
				pad = size;
			end
			size = aligned + {4'd0, a};
			if (a > big) big = a;
		end

		if (fmt.normal_format != 2'd0) begin
			a = ELEM_ALIGN[fmt.normal_format];
			aligned = vsd_align(size, a);
			if (!seen && aligned != size) begin
				seen = 1'b1;
				pad = size;
			end
			size = aligned + {3'd0, NRM_BYTES[fmt.normal_format]};
			if (a > big) big = a;
		end

		// position is always present
		a = POS_ALIGN[fmt.position_format];
		aligned = vsd_align(size, a);
		if (!seen && aligned != size) begin
			seen = 1'b1;
			pad = size;
		end
		posoff = aligned;
		size = aligned + {3'd0, POS_BYTES[fmt.position_format]};
		if (a > big) big = a;

		// final alignment to the widest component
		aligned = vsd_align(size, big);
		if (!seen && aligned != size) begin
			pad = size;
		end

		layout.vertex_stride   = {3'd0, aligned} * {6'd0, mc};
		layout.position_offset = posoff[5:0];
		layout.padding_offset  = pad;
	end

endmodule

[hw/rtl/vertex_stride_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_stride_decoder
// Vertex stride, position offset and first padding offset from format fields.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the seven format fields and raise start. An item is taken at a
//   rising edge with start high and busy low; busy stays low, so an item
//   can be taken at every edge.
//   The fields are registered, decoded by the layout logic and captured in
//   the result register. done rises at the edge after the accepting edge
//   and is high for a single cycle per item, with vertex_stride,
//   position_offset and padding_offset valid in that cycle.
//   Throughput is one item per cycle; the figure is set by the single
//   register-to-register decode path of the layout logic.
//   The receiver cannot stall: each result is shown for one cycle only and
//   must be taken then.
//   arst_n low clears both pipeline valid flags at once, so no result is
//   shown until a new item is accepted after reset.
// ----------------------------------------------------------------------------
module vertex_stride_decoder
	import vsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] tex_coord_format,
	input  logic [2:0] color_format,
	input  logic [1:0] normal_format,
	input  logic [1:0] position_format,
	input  logic [1:0] weight_format,
	input  logic [3:0] weight_count,
	input  logic [3:0] morph_count,
	output logic       done,
	output logic [9:0] vertex_stride,
	output logic [5:0] position_offset,
	output logic [6:0] padding_offset
);

	fmt_t    fmt_s1;
	logic    valid_s1;
	layout_t layout;
	layout_t layout_s2;
	logic    valid_s2;
	logic    accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_s1.tex_coord_format <= tex_coord_format;
			fmt_s1.color_format     <= color_format;
			fmt_s1.normal_format    <= normal_format;
			fmt_s1.position_format  <= position_format;
			fmt_s1.weight_format    <= weight_format;
			fmt_s1.weight_count     <= weight_count;
			fmt_s1.morph_count      <= morph_count;
		end
		if (valid_s1) begin
			layout_s2 <= layout;
		end
	end

	vsd_layout u_layout (
		.fmt    (fmt_s1),
		.layout (layout)
	);

	assign done            = valid_s2;
	assign vertex_stride   = layout_s2.vertex_stride;
	assign position_offset = layout_s2.position_offset;
	assign padding_offset  = layout_s2.padding_offset;

endmodule

[hw/rtl/vsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_checker
// Port-level checks on the vertex stride decoder, bound to the top level.
// ----------------------------------------------------------------------------
module vsd_checker
	import vsd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] tex_coord_format,
	input logic [2:0] color_format,
	input logic [1:0] normal_format,
	input logic [1:0] position_format,
	input logic [1:0] weight_format,
	input logic [3:0] weight_count,
	input logic [3:0] morph_count,
	input logic       done,
	input logic [9:0] vertex_stride,
	input logic [5:0] position_offset,
	input logic [6:0] padding_offset
);

	// every accepted item gives a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item gave no result");

	// no result without a matching accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted item");

	// format fields are known whenever an item is taken
	a_known_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !$isunknown({tex_coord_format, color_format, normal_format,
			position_format, weight_format, weight_count, morph_count}))
		else $error("unknown format field on accepted item");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (vertex_stride <= 10'(MAX_STRIDE) && position_offset <= 6'(MAX_POS_OFFSET)
			&& padding_offset <= 7'(MAX_PAD_OFFSET)))
		else $error("result field out of range");

	// the position lies inside the vertex
	a_pos_inside: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({4'd0, position_offset} + 10'd3 <= vertex_stride))
		else $error("position offset beyond stride");

endmodule

bind vertex_stride_decoder vsd_checker u_vsd_checker (.*);

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the vertex stride decoder against a layout calculator in the bench.
// A directed table covers empty and full layouts, count clamping and padding
// cases, then random format words follow. Start is dropped at random, and
// every result is compared with the oldest expected layout.
// ----------------------------------------------------------------------------
module tb;
	import vsd_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1830;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam logic [1:0]  FMT_NONE     = 2'd0;

	typedef struct packed {
		fmt_t    f;
		logic    typed;
		layout_t want;
	} stim_row_t;

	// fields: tex, color, normal, position, weight, weight count, morph count
	localparam int DIR_N = 22;
	localparam stim_row_t DIR_ROWS [DIR_N] = '{
		{2'd0, 3'd0, 2'd0, 2'd0, 2'd0, 4'd0,  4'd0,  1'b1, 10'd3,   6'd0,  7'd0},
		{2'd3, 3'd7, 2'd3, 2'd3, 2'd3, 4'd8,  4'd8,  1'b1, 10'd544, 6'd56, 7'd0},
		{2'd3, 3'd7, 2'd3, 2'd3, 2'd3, 4'd15, 4'd15, 1'b1, 10'd544, 6'd56, 7'd0},
		{2'd3, 3'd0, 2'd0, 2'd3, 2'd1, 4'd1,  4'd1,  1'b1, 10'd24,  6'd12, 7'd1},
		{2'd0, 3'd0, 2'd0, 2'd0, 2'd2, 4'd1,  4'd2,  1'b1, 10'd12,  6'd2,  7'd5},
		{2'd1, 3'd7, 2'd0, 2'd0, 2'd0, 4'd1,  4'd1,  1'b1, 10'd12,  6'd8,  7'd2},
		{2'd0, 3'd0, 2'd0, 2'd2, 2'd0, 4'd1,  4'd1,  1'b1, 10'd6,   6'd0,  7'd0},
		{2'd0, 3'd0, 2'd0, 2'd1, 2'd0, 4'd1,  4'd1,  1'b1, 10'd3,   6'd0,  7'd0},
		{2'd1, 3'd0, 2'd0, 2'd0, 2'd0, 4'd1,  4'd1,  1'b0, 23'd0},
		{2'd2, 3'd4, 2'd0, 2'd0, 2'd0, 4'd1,  4'd1,  1'b0, 23'd0},
		{2'd0, 3'd5, 2'd0, 2'd0, 2'd0, 4'd1,  4'd1,  1'b0, 23'd0},
		{2'd0, 3'd6, 2'd1, 2'd0, 2'd0, 4'd1,  4'd1,  1'b0, 23'd0},
		{2'd0, 3'd3, 2'd2, 2'd2, 2'd0, 4'd1,  4'd1,  1'b0, 23'd0},
		{2'd0, 3'd0, 2'd3, 2'd3, 2'd1, 4'd3,  4'd1,  1'b0, 23'd0},
		{2'd0, 3'd1, 2'd1, 2'd0, 2'd1, 4'd8,  4'd1,  1'b0, 23'd0},
		{2'd2, 3'd2, 2'd2, 2'd1, 2'd2, 4'd7,  4'd3,  1'b0, 23'd0},
		{2'd3, 3'd7, 2'd0, 2'd0, 2'd1, 4'd5,  4'd7,  1'b0, 23'd0},
		{2'd1, 3'd4, 2'd1, 2'd1, 2'd3, 4'd0,  4'd9,  1'b0, 23'd0},
		{2'd0, 3'd0, 2'd0, 2'd3, 2'd1, 4'd1,  4'd1,  1'b0, 23'd0},
		{2'd2, 3'd7, 2'd1, 2'd0, 2'd2, 4'd9,  4'd4,  1'b0, 23'd0},
		{2'd1, 3'd6, 2'd3, 2'd2, 2'd1, 4'd3,  4'd5,  1'b0, 23'd0},
		{2'd0, 3'd7, 2'd0, 2'd0, 2'd0, 4'd1,  4'd1,  1'b0, 23'd0}
	};

	// component sizes and alignments by format code
	int unsigned tc_size   [4] = '{0, 2, 4, 8};
	int unsigned col_size  [8] = '{0, 0, 0, 0, 2, 2, 2, 4};
	int unsigned nrm_size  [4] = '{0, 3, 6, 12};
	int unsigned pos_span  [4] = '{3, 3, 6, 12};
	int unsigned elem_size [4] = '{0, 1, 2, 4};
	int unsigned pos_elem  [4] = '{1, 1, 2, 4};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] tex_coord_format = '0;
	logic [2:0] color_format = '0;
	logic [1:0] normal_format = '0;
	logic [1:0] position_format = '0;
	logic [1:0] weight_format = '0;
	logic [3:0] weight_count = '0;
	logic [3:0] morph_count = '0;
	logic       done;
	logic [9:0] vertex_stride;
	logic [5:0] position_offset;
	logic [6:0] padding_offset;

	layout_t     layout_q [$];
	int unsigned n_errors = 0;
	int unsigned n_items = 0;
	int unsigned n_results = 0;
	int unsigned n_padded = 0;
	int unsigned n_clamped = 0;

	always #5 clk = ~clk;

	vertex_stride_decoder u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.tex_coord_format(tex_coord_format),
		.color_format    (color_format),
		.normal_format   (normal_format),
		.position_format (position_format),
		.weight_format   (weight_format),
		.weight_count    (weight_count),
		.morph_count     (morph_count),
		.done            (done),
		.vertex_stride   (vertex_stride),
		.position_offset (position_offset),
		.padding_offset  (padding_offset)
	);

	function automatic int unsigned clamp_count(input logic [3:0] cnt);
		if (cnt == 4'd0) begin
			return 1;
		end
		return (cnt > 4'd8) ? 8 : cnt;
	endfunction

	// round up to a multiple of a power-of-two alignment; remember where the first gap opened
	function automatic void fit_align(inout int unsigned size, input int unsigned a,
			inout bit gap_seen, inout int unsigned gap_at);
		int unsigned m;
		int unsigned r;
		m = a - 1;
		r = (size + m) & ~m;
		if (!gap_seen && r != size) begin
			gap_seen = 1'b1;
			gap_at = size;
		end
		size = r;
	endfunction

	function automatic layout_t stride_layout(input fmt_t f);
		int unsigned size;
		int unsigned widest;
		int unsigned gap_at;
		int unsigned pos_at;
		int unsigned a;
		bit          gap_seen;
		layout_t     res;
		size = 0;
		widest = 0;
		gap_at = 0;
		gap_seen = 1'b0;
		// weights sit at offset zero, no alignment needed
		if (f.weight_format != FMT_NONE) begin
			a = elem_size[f.weight_format];
			size = a * clamp_count(f.weight_count);
			widest = a;
		end
		if (f.tex_coord_format != FMT_NONE) begin
			a = elem_size[f.tex_coord_format];
			fit_align(size, a, gap_seen, gap_at);
			size += tc_size[f.tex_coord_format];
			widest = (a > widest) ? a : widest;
		end
		if (col_size[f.color_format] != 0) begin
			a = col_size[f.color_format];
			fit_align(size, a, gap_seen, gap_at);
			size += a;
			widest = (a > widest) ? a : widest;
		end
		if (f.normal_format != FMT_NONE) begin
			a = elem_size[f.normal_format];
			fit_align(size, a, gap_seen, gap_at);
			size += nrm_size[f.normal_format];
			widest = (a > widest) ? a : widest;
		end
		// position is always there, code zero lays out as bytes
		a = pos_elem[f.position_format];
		fit_align(size, a, gap_seen, gap_at);
		pos_at = size;
		size += pos_span[f.position_format];
		widest = (a > widest) ? a : widest;
		fit_align(size, widest, gap_seen, gap_at);
		size = size * clamp_count(f.morph_count);
		res.vertex_stride = size[9:0];
		res.position_offset = pos_at[5:0];
		res.padding_offset = gap_at[6:0];
		return res;
	endfunction

	function automatic fmt_t random_format();
		fmt_t f;
		f.tex_coord_format = 2'($urandom_range(3));
		f.color_format = 3'($urandom_range(7));
		f.normal_format = 2'($urandom_range(3));
		f.position_format = 2'($urandom_range(3));
		f.weight_format = 2'($urandom_range(3));
		// mostly legal counts, the rest across the whole field
		f.weight_count = ($urandom_range(3) != 0) ? 4'($urandom_range(8, 1))
			: 4'($urandom_range(15));
		f.morph_count = ($urandom_range(3) != 0) ? 4'($urandom_range(8, 1))
			: 4'($urandom_range(15));
		return f;
	endfunction

	task automatic send_item(input fmt_t f, input layout_t want, input bit may_idle);
		while (may_idle && $urandom_range(99) < 10) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		tex_coord_format <= f.tex_coord_format;
		color_format <= f.color_format;
		normal_format <= f.normal_format;
		position_format <= f.position_format;
		weight_format <= f.weight_format;
		weight_count <= f.weight_count;
		morph_count <= f.morph_count;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		layout_q.push_back(want);
		n_items++;
		if (want.padding_offset != 0) begin
			n_padded++;
		end
		if (f.weight_count == 0 || f.weight_count > 8 || f.morph_count == 0
				|| f.morph_count > 8) begin
			n_clamped++;
		end
	endtask

	always @(posedge clk) begin
		layout_t want;
		if (arst_n && done === 1'b1) begin
			n_results++;
			if (layout_q.size() == 0) begin
				$error("unexpected result: stride %0d", vertex_stride);
				n_errors++;
			end else begin
				want = layout_q.pop_front();
				if (vertex_stride !== want.vertex_stride) begin
					$error("vertex_stride: expected %0d, got %0d", want.vertex_stride,
						vertex_stride);
					n_errors++;
				end
				if (position_offset !== want.position_offset) begin
					$error("position_offset: expected %0d, got %0d", want.position_offset,
						position_offset);
					n_errors++;
				end
				if (padding_offset !== want.padding_offset) begin
					$error("padding_offset: expected %0d, got %0d", want.padding_offset,
						padding_offset);
					n_errors++;
				end
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		int unsigned quiet;
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		fmt_t    f;
		layout_t want;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_N; i++) begin
			f = DIR_ROWS[i].f;
			want = DIR_ROWS[i].typed ? DIR_ROWS[i].want : stride_layout(f);
			send_item(f, want, 1'b1);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			f = random_format();
			// back-to-back stretch in the middle of the run
			send_item(f, stride_layout(f), !(i >= 800 && i < 1200));
		end
		start <= 1'b0;
		while (layout_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d format words sent, %0d layouts checked", n_items, n_results);
		$display("%0d with a padding gap, %0d with clamped counts", n_padded, n_clamped);
		if (n_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
